@@ rtl/oaht_pkg.sv @@
// ----------------------------------------------------------------------------
// oaht_pkg - shared types and constants for the open-addressing hash table
// Table geometry, request/response structs, command and status codes, and
// the control bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package oaht_pkg;

   localparam int TABLE_SIZE = 16;
   localparam int IDX_W      = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
   localparam int NUM_W      = 34;
   localparam int SLOT_W     = 4;
   localparam int CMD_W      = 2;
   localparam int STATUS_W   = 3;

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

   localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
   localparam logic [STATUS_W-1:0] ST_READ      = 3'd4;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [NUM_W-1:0]  number;
      logic              probe_mode;
      logic [SLOT_W-1:0] slot_index;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
      logic                occupied;
      logic [NUM_W-1:0]    number_out;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic                load_req;
      logic                probe_next;
      logic                write_slot;
      logic                clear_slot;
      logic                scan_next;
      logic                rsp_load;
      logic [STATUS_W-1:0] rsp_status;
   } ctl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic slot_empty;
      logic probe_last;
      logic match;
      logic scan_last;
      logic rsp_free;
   } dp_stat_type;

   function automatic logic [SLOT_W-1:0] slot_from_idx(input logic [IDX_W-1:0] idx);
      logic [IDX_W+SLOT_W-1:0] t;
      t = {{SLOT_W{1'b0}}, idx};
      return t[SLOT_W-1:0];
   endfunction

   function automatic logic [IDX_W-1:0] idx_from_slot(input logic [SLOT_W-1:0] slot);
      logic [IDX_W+SLOT_W-1:0] t;
      t = {{IDX_W{1'b0}}, slot};
      return t[IDX_W-1:0];
   endfunction

   function automatic logic slot_in_range(input logic [SLOT_W-1:0] slot);
      logic [IDX_W+SLOT_W-1:0] t;
      t = {{IDX_W{1'b0}}, slot};
      return t < (IDX_W+SLOT_W)'(TABLE_SIZE);
   endfunction

endpackage

@@ rtl/open_addressing_hash_table_top.sv @@
// ----------------------------------------------------------------------------
// open_addressing_hash_table_top - open-addressing table of 34-bit numbers
// Insert with linear or quadratic probing, delete by value, read by slot.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on req_valid/req_data while req_stall is low; each
//   request produces exactly one response on rsp_valid/rsp_data, taken
//   when rsp_stall is low. One request is worked at a time.
//   Steps from acceptance to rsp_valid (response register free):
//     insert: the home slot (number modulo TABLE_SIZE) is taken on the
//             accepting edge, then the probe walk moves slot by slot,
//             1 to TABLE_SIZE probes;
//     delete: a read state and a compare state per slot scanned
//             (registered memory read), 1 to TABLE_SIZE slots;
//     read:   a wait state for the registered read, then the response.
//   The next request is taken in the cycle after the response is loaded;
//   no new request enters before the last one's response is loaded. The
//   probe walk and the one-read-port number memory set these sequences.
//   The response register lets a new request enter while the last response
//   waits; if it is still held when the next result is ready, the
//   controller waits in place. Reset empties the table at once (valid bits
//   cleared) and drops any pending response; no clearing pass is needed.
// ----------------------------------------------------------------------------
module open_addressing_hash_table_top
   import oaht_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   ctl_cmd_type cmd;
   dp_stat_type stat;

   // sequence each request
   oaht_controller u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_data.command),
      .req_stall   (req_stall),
      .stat        (stat),
      .cmd         (cmd)
   );

   // hold the table and the response register
   oaht_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // a slot is written only when found empty
   assert property (@(posedge clock) disable iff (reset)
      cmd.write_slot |-> stat.slot_empty)
      else $error("insert wrote an occupied slot");

   // a slot is cleared only on a matching number
   assert property (@(posedge clock) disable iff (reset)
      cmd.clear_slot |-> stat.match)
      else $error("delete cleared a non-matching slot");

   // never overwrite a response that is still waiting
   assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> stat.rsp_free)
      else $error("response overwritten while stalled");

   // an accepted request keeps the input closed next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second request accepted while busy");

endmodule

@@ rtl/oaht_datapath.sv @@
// ----------------------------------------------------------------------------
// oaht_datapath - slot storage, probe arithmetic and response register
// Holds the number memory and valid bits, takes the starting slot on load,
// steps the probe sequence or the delete scan and assembles the response.
// ----------------------------------------------------------------------------
module oaht_datapath
   import oaht_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_data,
   input  ctl_cmd_type cmd,
   output dp_stat_type stat,
   input  logic        rsp_stall,
   output logic        rsp_valid,
   output rsp_type     rsp_data
);

   logic [NUM_W-1:0] mem [TABLE_SIZE];
   logic [NUM_W-1:0] rd_data_ff;

   logic [TABLE_SIZE-1:0] valid_ff, valid_in;
   req_type               req_ff;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [IDX_W-1:0]      step_ff, step_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic [IDX_W-1:0] home;
   logic [IDX_W:0]   odd, delta, psum, pnext;
   logic             rsp_free;
   logic             rd_in_range;

   // home slot: number modulo the power-of-two table size
   assign home = IDX_W'(req_data.number % NUM_W'(TABLE_SIZE));

   // quadratic offsets advance by 2i+1
   assign odd   = {step_ff, 1'b1};
   assign delta = !req_ff.probe_mode ? (IDX_W+1)'(1) :
                  (odd >= (IDX_W+1)'(TABLE_SIZE)) ? odd - (IDX_W+1)'(TABLE_SIZE) : odd;
   assign psum  = {1'b0, idx_ff} + delta;
   assign pnext = (psum >= (IDX_W+1)'(TABLE_SIZE)) ? psum - (IDX_W+1)'(TABLE_SIZE) : psum;

   assign rsp_free    = !rsp_valid_ff || !rsp_stall;
   assign rd_in_range = slot_in_range(req_ff.slot_index);

   assign stat.slot_empty = !valid_ff[idx_ff];
   assign stat.probe_last = (step_ff == IDX_W'(TABLE_SIZE - 1));
   assign stat.match      = valid_ff[idx_ff] && (rd_data_ff == req_ff.number);
   assign stat.scan_last  = (idx_ff == IDX_W'(TABLE_SIZE - 1));
   assign stat.rsp_free   = rsp_free;

   always_comb begin
      idx_in       = idx_ff;
      step_in      = step_ff;
      valid_in     = valid_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (cmd.load_req) begin
         step_in = '0;
         if (req_data.command == CMD_INSERT) begin
            idx_in = home;
         end else if (req_data.command == CMD_DELETE) begin
            idx_in = '0;
         end else begin
            idx_in = idx_from_slot(req_data.slot_index);
         end
      end
      if (cmd.probe_next) begin
         idx_in  = pnext[IDX_W-1:0];
         step_in = step_ff + 1'b1;
      end
      if (cmd.scan_next) begin
         idx_in = idx_ff + 1'b1;
      end
      if (cmd.write_slot) begin
         valid_in[idx_ff] = 1'b1;
      end
      if (cmd.clear_slot) begin
         valid_in[idx_ff] = 1'b0;
      end
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_valid_in      = 1'b1;
         rsp_in.status     = cmd.rsp_status;
         rsp_in.slot       = '0;
         rsp_in.occupied   = 1'b0;
         rsp_in.number_out = '0;
         case (cmd.rsp_status)
            ST_INSERTED, ST_DELETED: begin
               rsp_in.slot = slot_from_idx(idx_ff);
            end
            ST_READ: begin
               rsp_in.slot = req_ff.slot_index;
               if (rd_in_range && valid_ff[idx_ff]) begin
                  rsp_in.occupied   = 1'b1;
                  rsp_in.number_out = rd_data_ff;
               end
            end
            default: begin
               rsp_in.slot = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write_slot) begin
         mem[idx_ff] <= req_ff.number;
      end
      rd_data_ff <= mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff  <= idx_in;
      step_ff <= step_in;
      rsp_ff  <= rsp_in;
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ rtl/oaht_controller.sv @@
// ----------------------------------------------------------------------------
// oaht_controller - command sequencer for the hash table
// Steps each request through probing, scanning or a slot read and issues
// the datapath commands.
// ----------------------------------------------------------------------------
module oaht_controller
   import oaht_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic [CMD_W-1:0] req_command,
   output logic             req_stall,
   input  dp_stat_type      stat,
   output ctl_cmd_type      cmd
);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_PROBE   = 3'd2;
   localparam logic [2:0] S_DEL_RD  = 3'd3;
   localparam logic [2:0] S_DEL_CMP = 3'd4;
   localparam logic [2:0] S_RD_WAIT = 3'd5;
   localparam logic [2:0] S_RD_DONE = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       accept;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.rsp_status = ST_READ;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.load_req = 1'b1;
               case (req_command)
                  CMD_INSERT: state_in = S_PROBE;
                  CMD_DELETE: state_in = S_DEL_RD;
                  default:    state_in = S_RD_WAIT;
               endcase
            end
         end
         S_PROBE: begin
            if (stat.slot_empty) begin
               if (stat.rsp_free) begin
                  cmd.write_slot = 1'b1;
                  cmd.rsp_load   = 1'b1;
                  cmd.rsp_status = ST_INSERTED;
                  state_in       = S_IDLE;
               end
            end else if (stat.probe_last) begin
               if (stat.rsp_free) begin
                  cmd.rsp_load   = 1'b1;
                  cmd.rsp_status = ST_FULL;
                  state_in       = S_IDLE;
               end
            end else begin
               cmd.probe_next = 1'b1;
            end
         end
         S_DEL_RD: begin
            state_in = S_DEL_CMP;
         end
         S_DEL_CMP: begin
            if (stat.match) begin
               if (stat.rsp_free) begin
                  cmd.clear_slot = 1'b1;
                  cmd.rsp_load   = 1'b1;
                  cmd.rsp_status = ST_DELETED;
                  state_in       = S_IDLE;
               end
            end else if (stat.scan_last) begin
               if (stat.rsp_free) begin
                  cmd.rsp_load   = 1'b1;
                  cmd.rsp_status = ST_NOT_FOUND;
                  state_in       = S_IDLE;
               end
            end else begin
               cmd.scan_next = 1'b1;
               state_in      = S_DEL_RD;
            end
         end
         S_RD_WAIT: begin
            state_in = S_RD_DONE;
         end
         S_RD_DONE: begin
            if (stat.rsp_free) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = ST_READ;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
